// ----- hdl/sliding_window_receiver_defines.svh -----
// Assertion macros shared by the sliding window receiver RTL.
`ifndef SLIDING_WINDOW_RECEIVER_DEFINES_SVH
`define SLIDING_WINDOW_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every rising edge, skipped while reset is held.
`define SWR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every rising edge, reset included.
`define SWR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SWR_ASSERT(lbl, prop, msg)
`define SWR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/swr_pkg.sv -----
// Shared types and constants of the sliding window receiver.
`default_nettype none

package swr_pkg;

  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned WSIZE_W    = 7;
  localparam int unsigned WSIZE_RST  = 64;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DATA  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd3;

  typedef enum logic [1:0] {
    OP_START,
    OP_END,
    OP_DATA
  } swr_op_e;

  typedef struct packed {
    swr_op_e          op;
    logic [SEQ_W-1:0] seq;
  } swr_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/swr_front.sv -----
// Header intake: classify each beat and push packet commands into the queue.
`default_nettype none

module swr_front
  import swr_pkg::*;
(
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [SEQ_W-1:0]  s_axis_tdata,   // seq_num
  input  wire logic [MODE_W-1:0] s_axis_tuser,   // mode
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output swr_cmd_t               q_cmd_o
);

  logic    keep;
  swr_op_e op;

  always_comb begin
    keep = 1'b1;
    op   = OP_START;
    case (s_axis_tuser)
      MODE_START: op = OP_START;
      MODE_END:   op = OP_END;
      MODE_DATA:  op = OP_DATA;
      MODE_ACK:   keep = 1'b0;
      default:    keep = 1'b0;
    endcase
  end

  // drop ack beats here, they never reach the back end
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i && keep;
  assign q_cmd_o.op    = op;
  assign q_cmd_o.seq   = s_axis_tdata;

endmodule

`default_nettype wire

// ----- hdl/swr_queue.sv -----
// Short command queue between the intake and the window engine.
`default_nettype none

`include "sliding_window_receiver_defines.svh"

module swr_queue
  import swr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  swr_cmd_t      cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  wire logic     pop_i,
  output swr_cmd_t      cmd_o
);

  swr_cmd_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;

  assign full_o  = count_q == QCNT_W'(QDEPTH);
  assign valid_o = count_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `SWR_ASSERT(a_count_bound, count_q <= QCNT_W'(QDEPTH), "queue count over depth")
  `SWR_ASSERT(a_no_push_full, !(push_i && full_o), "push into full queue")
  `SWR_ASSERT(a_no_pop_empty, !(pop_i && !valid_o), "pop from empty queue")

endmodule

`default_nettype wire

// ----- hdl/swr_engine.sv -----
// Window engine: connection state, receive bitmap and the result register.
`default_nettype none

`include "sliding_window_receiver_defines.svh"

module swr_engine
  import swr_pkg::*;
#(
  parameter int unsigned MaxWindow = MAX_WINDOW
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic [WSIZE_W-1:0] cfg_data_i,
  input  wire logic               q_valid_i,
  input  swr_cmd_t                q_cmd_i,
  output logic                    q_pop_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [SEQ_W-1:0]        m_axis_tdata,   // ack_seq
  output logic [0:0]              m_axis_tuser    // data_accepted
);

  localparam int unsigned IdxW = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;
  localparam int unsigned CntW = $clog2(MaxWindow + 1);

  logic [WSIZE_W-1:0]   wsize_q;
  logic                 conn_q, conn_d;
  logic [SEQ_W-1:0]     id_q, id_d;
  logic [SEQ_W-1:0]     base_q, base_d;
  logic [MaxWindow-1:0] map_q, map_d;
  logic                 out_valid_q, out_valid_d;
  logic [SEQ_W-1:0]     out_seq_q, out_seq_d;
  logic                 out_acc_q, out_acc_d;

  logic                 out_free;
  logic [SEQ_W-1:0]     off;
  logic [SEQ_W-1:0]     eff_win;
  logic                 in_win;
  logic [MaxWindow-1:0] set_map;
  logic [MaxWindow-1:0] low_zero;
  logic [MaxWindow-1:0] ones_mask;
  logic [CntW-1:0]      run;
  logic [MaxWindow-1:0] adv_map;
  logic [SEQ_W-1:0]     adv_base;

  assign out_free = !out_valid_q || m_axis_tready;
  assign q_pop_o  = q_valid_i && out_free;

  assign off     = q_cmd_i.seq - base_q;
  assign eff_win = ({{(SEQ_W-WSIZE_W){1'b0}}, wsize_q} < SEQ_W'(MaxWindow))
                   ? {{(SEQ_W-WSIZE_W){1'b0}}, wsize_q} : SEQ_W'(MaxWindow);
  assign in_win  = off < eff_win;

  // set the bit, then count the received run from the base
  assign set_map   = map_q | (MaxWindow'(1) << off[IdxW-1:0]);
  assign low_zero  = ~set_map & (set_map + MaxWindow'(1));
  assign ones_mask = low_zero - MaxWindow'(1);
  assign run       = CntW'($countones(ones_mask));
  assign adv_map   = set_map >> run;
  assign adv_base  = base_q + SEQ_W'(run);

  always_comb begin
    conn_d      = conn_q;
    id_d        = id_q;
    base_d      = base_q;
    map_d       = map_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_seq_d   = out_seq_q;
    out_acc_d   = out_acc_q;
    if (q_pop_o) begin
      case (q_cmd_i.op)
        OP_START: begin
          if (!conn_q || id_q == q_cmd_i.seq) begin
            conn_d      = 1'b1;
            id_d        = q_cmd_i.seq;
            out_valid_d = 1'b1;
            out_seq_d   = q_cmd_i.seq;
            out_acc_d   = 1'b0;
          end
        end
        OP_DATA: begin
          if (conn_q && in_win) begin
            map_d       = adv_map;
            base_d      = adv_base;
            out_valid_d = 1'b1;
            out_seq_d   = adv_base;
            out_acc_d   = 1'b1;
          end
        end
        OP_END: begin
          if (conn_q && id_q == q_cmd_i.seq) begin
            conn_d = 1'b0;
            id_d   = '0;
            base_d = '0;
            map_d  = '0;
          end
          out_valid_d = 1'b1;
          out_seq_d   = q_cmd_i.seq;
          out_acc_d   = 1'b0;
        end
        default: begin
          out_valid_d = out_valid_q && !m_axis_tready;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q     <= WSIZE_W'(WSIZE_RST);
      conn_q      <= 1'b0;
      id_q        <= '0;
      base_q      <= '0;
      map_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        wsize_q <= cfg_data_i;
      end
      conn_q      <= conn_d;
      id_q        <= id_d;
      base_q      <= base_d;
      map_q       <= map_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_seq_q <= out_seq_d;
    out_acc_q <= out_acc_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_seq_q;
  assign m_axis_tuser  = out_acc_q;

  `SWR_ASSERT(a_base_bit_clear, map_q[0] == 1'b0, "received run not advanced past base")
  `SWR_ASSERT(a_idle_clear, conn_q || (base_q == '0 && map_q == '0 && id_q == '0),
              "window state left behind without connection")
  `SWR_ASSERT(a_stall_no_pop, (out_valid_q && !m_axis_tready) |-> !q_pop_o,
              "command taken while result stalled")

endmodule

`default_nettype wire

// ----- hdl/sliding_window_receiver.sv -----
// Top level of the sliding window receiver with cumulative acknowledgement.
`default_nettype none

// Takes one packet header per beat (mode in tuser, sequence number in tdata) and
// sustains one header per cycle while the queue is not full. Beats enter a two-entry
// command queue in the cycle they are accepted; ack-type beats are dropped at intake.
// The window engine takes one command per cycle while its result register is free
// and finishes it in that cycle: bit set, trailing-ones count and bitmap shift over
// MaxWindow bits set the cycle time. Each result is registered at the output. No
// clearing pass after reset; the configuration port is always ready.
module sliding_window_receiver
  import swr_pkg::*;
#(
  parameter int unsigned MaxWindow = MAX_WINDOW
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [SEQ_W-1:0]   s_axis_tdata,   // seq_num
  input  wire logic [MODE_W-1:0]  s_axis_tuser,   // mode
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [SEQ_W-1:0]        m_axis_tdata,   // ack_seq
  output logic [0:0]              m_axis_tuser,   // data_accepted
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [WSIZE_W-1:0] cfg_data_i      // window length
);

  logic     q_full;
  logic     q_push;
  swr_cmd_t q_in;
  logic     q_valid;
  logic     q_pop;
  swr_cmd_t q_out;

  assign cfg_ready_o = 1'b1;

  swr_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (q_in)
  );

  swr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_out)
  );

  swr_engine #(
    .MaxWindow (MaxWindow)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- tb/sv/sliding_window_receiver_tb.sv -----
// Self-checking testbench of the sliding window receiver: directed headers, random traffic.
module sliding_window_receiver_tb;
  import swr_pkg::*;

  class ack_board;
    typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic             accepted;
    } ack_t;

    ack_t                  acks_due[$];
    bit                    linked;
    logic [SEQ_W-1:0]      link_id;
    logic [SEQ_W-1:0]      base;
    logic [MAX_WINDOW-1:0] got_map;
    logic [WSIZE_W-1:0]    wsize;
    int                    errors;

    function new();
      wsize  = WSIZE_W'(WSIZE_RST);
      errors = 0;
      clear_link();
    endfunction

    function void clear_link();
      linked  = 1'b0;
      link_id = '0;
      base    = '0;
      got_map = '0;
    endfunction

    function void set_window(logic [WSIZE_W-1:0] v);
      wsize = v;
    endfunction

    function int unsigned span();
      return (wsize > MAX_WINDOW) ? MAX_WINDOW : wsize;
    endfunction

    function void note_header(logic [MODE_W-1:0] mode, logic [SEQ_W-1:0] seq);
      logic [SEQ_W-1:0] off;
      int unsigned      run;
      case (mode)
        MODE_START: begin
          if (!linked || link_id == seq) begin
            linked  = 1'b1;
            link_id = seq;
            acks_due.push_back('{seq: seq, accepted: 1'b0});
          end
        end
        MODE_DATA: begin
          off = seq - base;
          if (linked && off < span()) begin
            got_map[off] = 1'b1;
            run = 0;
            while (run < MAX_WINDOW && got_map[run]) run++;
            got_map = got_map >> run;
            base    = base + run;
            acks_due.push_back('{seq: base, accepted: 1'b1});
          end
        end
        MODE_END: begin
          if (linked && link_id == seq) clear_link();
          acks_due.push_back('{seq: seq, accepted: 1'b0});
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_ack(logic [SEQ_W-1:0] seq, logic accepted);
      ack_t want;
      if (acks_due.size() == 0) begin
        report($sformatf("unexpected ack seq %h accepted %b", seq, accepted));
        return;
      end
      want = acks_due.pop_front();
      if (seq !== want.seq)
        report($sformatf("ack_seq %h, want %h", seq, want.seq));
      if (accepted !== want.accepted)
        report($sformatf("data_accepted %b, want %b (ack_seq %h)", accepted, want.accepted,
                         want.seq));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SEQ_W-1:0]     s_axis_tdata = '0;
  logic [MODE_W-1:0]    s_axis_tuser = MODE_ACK;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SEQ_W-1:0]     m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [WSIZE_W-1:0]   cfg_data_i = '0;

  ack_board    sb = new();
  bit          calm = 1'b0;
  int unsigned stall_left = 0;

  sliding_window_receiver dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // seq_num
    .s_axis_tuser (s_axis_tuser),   // mode
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // ack_seq
    .m_axis_tuser (m_axis_tuser),   // data_accepted
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)      // window length
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_ack(m_axis_tdata, m_axis_tuser[0]);
    if (stall_left == 0) stall_left = pick_gap();
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_header(logic [MODE_W-1:0] mode, logic [SEQ_W-1:0] seq);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seq;
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_header(mode, seq);
  endtask

  task automatic write_window(logic [WSIZE_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.acks_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_window(v);
  endtask

  task automatic run_traffic(int unsigned n);
    int unsigned       sent;
    int unsigned       pick;
    logic [MODE_W-1:0] mode;
    logic [SEQ_W-1:0]  seq;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (!sb.linked && pick < 60) begin
        mode = MODE_START;
        seq  = $urandom;
      end else if (pick < 65) begin
        mode = MODE_DATA;
        if ($urandom_range(0, 1)) seq = sb.base + $urandom_range(0, 3);
        else seq = sb.base + $urandom_range(0, sb.span() + 1);
      end else if (pick < 72) begin
        mode = MODE_START;
        seq  = $urandom_range(0, 1) ? sb.link_id : $urandom;
      end else if (pick < 80) begin
        mode = MODE_END;
        seq  = ($urandom_range(0, 3) == 0) ? sb.link_id : $urandom;
      end else if (pick < 85) begin
        mode = MODE_ACK;
        seq  = $urandom;
      end else if (pick < 92) begin
        mode = MODE_DATA;
        seq  = $urandom;
      end else if (pick < 96) begin
        mode = MODE_DATA;
        seq  = sb.base - $urandom_range(1, 4);
      end else begin
        mode = MODE_W'($urandom_range(0, 3));
        seq  = $urandom;
      end
      send_header(mode, seq);
      if (mode != MODE_ACK) sent++;
    end
  endtask

  initial begin
    logic [WSIZE_W-1:0] windows[$];
    windows = '{7'd1, 7'd127, 7'd0, 7'd64, 7'd2, 7'd63, 7'd65, 7'd0, 7'd0};
    windows[7] = WSIZE_W'($urandom_range(3, 62));
    windows[8] = WSIZE_W'($urandom_range(66, 127));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no connection yet
    send_header(MODE_DATA, 32'd0);
    send_header(MODE_END, 32'd0);
    send_header(MODE_ACK, 32'hFFFF_FFFF);
    // open, foreign start, repeat start, foreign end
    send_header(MODE_START, 32'hFFFF_FFFF);
    send_header(MODE_START, 32'h1234_5678);
    send_header(MODE_START, 32'hFFFF_FFFF);
    send_header(MODE_END, 32'd0);
    // out of order, duplicate, then the gap fills
    send_header(MODE_DATA, 32'd1);
    send_header(MODE_DATA, 32'd1);
    send_header(MODE_DATA, 32'd0);
    send_header(MODE_DATA, 32'd65);
    send_header(MODE_DATA, 32'd66);
    send_header(MODE_DATA, 32'd1);
    send_header(MODE_DATA, 32'hFFFF_FFFF);
    send_header(MODE_DATA, 32'd2);
    send_header(MODE_ACK, 32'd3);
    // close, then data is dropped
    send_header(MODE_END, 32'hFFFF_FFFF);
    send_header(MODE_DATA, 32'd0);
    send_header(MODE_END, 32'hFFFF_FFFF);

    calm = 1'b1;
    run_traffic(40);
    calm = 1'b0;
    foreach (windows[i]) begin
      write_window(windows[i]);
      calm = (i % 3 == 2);
      run_traffic(50);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.acks_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("sliding_window_receiver verification clean");
    end else begin
      $display("sliding_window_receiver verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sliding_window_receiver verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/swr_pkg.sv
hdl/swr_front.sv
hdl/swr_queue.sv
hdl/swr_engine.sv
hdl/sliding_window_receiver.sv
tb/sv/sliding_window_receiver_tb.sv
